>>> hw/rtl/msgd_pkg.sv
// Package with the shared types and header codes of the MessagePack stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package msgd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_OPER    = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        PK_FLOAT = 4'd0,
        PK_U8    = 4'd1,
        PK_U16   = 4'd2,
        PK_U32   = 4'd3,
        PK_I8    = 4'd4,
        PK_I16   = 4'd5,
        PK_I32   = 4'd6,
        PK_RAW16 = 4'd7,
        PK_RAW32 = 4'd8
    } pend_t;

    typedef enum logic [2:0] {
        K_NIL     = 3'd0,
        K_BOOL    = 3'd1,
        K_UINT    = 3'd2,
        K_INT     = 3'd3,
        K_RAWHDR  = 3'd4,
        K_RAWBYTE = 3'd5,
        K_FLOAT   = 3'd6,
        K_UNSUP   = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value_bits;
        logic        last;
    } result_t;

    localparam logic [7:0] HDR_NIL     = 8'hC0;
    localparam logic [7:0] HDR_FALSE   = 8'hC2;
    localparam logic [7:0] HDR_TRUE    = 8'hC3;
    localparam logic [7:0] HDR_FLOAT32 = 8'hCA;
    localparam logic [7:0] HDR_UINT8   = 8'hCC;
    localparam logic [7:0] HDR_UINT16  = 8'hCD;
    localparam logic [7:0] HDR_UINT32  = 8'hCE;
    localparam logic [7:0] HDR_INT8    = 8'hD0;
    localparam logic [7:0] HDR_INT16   = 8'hD1;
    localparam logic [7:0] HDR_INT32   = 8'hD2;
    localparam logic [7:0] HDR_RAW16   = 8'hDA;
    localparam logic [7:0] HDR_RAW32   = 8'hDB;

    localparam logic [2:0] FIXRAW_TAG = 3'b101;
    localparam logic [2:0] NEGFIX_TAG = 3'b111;

endpackage

`default_nettype wire

>>> hw/rtl/msgd_if.sv
// Stream interfaces for encoded bytes in and decoded results out.
`timescale 1ns / 1ps
`default_nettype none

interface msgd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

interface msgd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] value_bits;
    logic        last;

    modport source (output valid, output kind, output value_bits, output last, input ready);
    modport sink (input valid, input kind, input value_bits, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/msgd_core.sv
// Decoder state and the combinational step that turns one byte into at most one result.
`timescale 1ns / 1ps
`default_nettype none

module msgd_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        byte_in,
    output msgd_pkg::result_t      result,
    output logic                   has_result
);

    msgd_pkg::phase_t phase_reg, phase_next;
    msgd_pkg::pend_t  pending_reg, pending_next;
    logic [2:0]       left_reg, left_next;
    logic [31:0]      acc_reg, acc_next;
    logic [31:0]      payload_reg, payload_next;

    logic [31:0]       acc_shift;
    logic              op_done;
    logic              in_oper;
    logic              in_payload;

    // Header decode results.
    logic              hdr_emit;
    msgd_pkg::result_t hdr_res;
    logic              hdr_start;
    msgd_pkg::pend_t   hdr_pk;
    logic [2:0]        hdr_nbytes;
    logic              hdr_raw;
    logic [4:0]        hdr_len;

    // Operand completion results.
    msgd_pkg::result_t fin_res;
    logic              fin_raw;

    assign acc_shift  = {acc_reg[23:0], byte_in};
    assign op_done    = (left_reg <= 3'd1);
    assign in_oper    = (phase_reg == msgd_pkg::PH_OPER);
    assign in_payload = (phase_reg == msgd_pkg::PH_PAYLOAD) && (payload_reg != 32'd0);

    always_comb
    begin
        hdr_emit   = 1'b1;
        hdr_res    = '{msgd_pkg::K_UNSUP, {24'd0, byte_in}, 1'b1};
        hdr_start  = 1'b0;
        hdr_pk     = msgd_pkg::PK_FLOAT;
        hdr_nbytes = 3'd0;
        hdr_raw    = 1'b0;
        hdr_len    = byte_in[4:0];
        if (!byte_in[7])
        begin
            hdr_res = '{msgd_pkg::K_UINT, {24'd0, byte_in}, 1'b1};
        end
        else if (byte_in[7:5] == msgd_pkg::NEGFIX_TAG)
        begin
            hdr_res = '{msgd_pkg::K_INT, {24'hFFFFFF, byte_in}, 1'b1};
        end
        else if (byte_in[7:5] == msgd_pkg::FIXRAW_TAG)
        begin
            hdr_raw = 1'b1;
            hdr_res = '{msgd_pkg::K_RAWHDR, {27'd0, hdr_len}, (hdr_len == 5'd0)};
        end
        else
        begin
            case (byte_in)
                msgd_pkg::HDR_NIL:   hdr_res = '{msgd_pkg::K_NIL, 32'd0, 1'b1};
                msgd_pkg::HDR_FALSE: hdr_res = '{msgd_pkg::K_BOOL, 32'd0, 1'b1};
                msgd_pkg::HDR_TRUE:  hdr_res = '{msgd_pkg::K_BOOL, 32'd1, 1'b1};
                msgd_pkg::HDR_FLOAT32:
                begin
                    hdr_start  = 1'b1;
                    hdr_pk     = msgd_pkg::PK_FLOAT;
                    hdr_nbytes = 3'd4;
                end
                msgd_pkg::HDR_UINT8:
                begin
                    hdr_start  = 1'b1;
                    hdr_pk     = msgd_pkg::PK_U8;
                    hdr_nbytes = 3'd1;
                end
                msgd_pkg::HDR_UINT16:
                begin
                    hdr_start  = 1'b1;
                    hdr_pk     = msgd_pkg::PK_U16;
                    hdr_nbytes = 3'd2;
                end
                msgd_pkg::HDR_UINT32:
                begin
                    hdr_start  = 1'b1;
                    hdr_pk     = msgd_pkg::PK_U32;
                    hdr_nbytes = 3'd4;
                end
                msgd_pkg::HDR_INT8:
                begin
                    hdr_start  = 1'b1;
                    hdr_pk     = msgd_pkg::PK_I8;
                    hdr_nbytes = 3'd1;
                end
                msgd_pkg::HDR_INT16:
                begin
                    hdr_start  = 1'b1;
                    hdr_pk     = msgd_pkg::PK_I16;
                    hdr_nbytes = 3'd2;
                end
                msgd_pkg::HDR_INT32:
                begin
                    hdr_start  = 1'b1;
                    hdr_pk     = msgd_pkg::PK_I32;
                    hdr_nbytes = 3'd4;
                end
                msgd_pkg::HDR_RAW16:
                begin
                    hdr_start  = 1'b1;
                    hdr_pk     = msgd_pkg::PK_RAW16;
                    hdr_nbytes = 3'd2;
                end
                msgd_pkg::HDR_RAW32:
                begin
                    hdr_start  = 1'b1;
                    hdr_pk     = msgd_pkg::PK_RAW32;
                    hdr_nbytes = 3'd4;
                end
                default: hdr_res = '{msgd_pkg::K_UNSUP, {24'd0, byte_in}, 1'b1};
            endcase
            hdr_emit = !hdr_start;
        end
    end

    // Result of the byte that completes an operand. Short operands start from
    // a cleared accumulator, so only the sign needs extending.
    always_comb
    begin
        fin_raw = 1'b0;
        case (pending_reg)
            msgd_pkg::PK_FLOAT: fin_res = '{msgd_pkg::K_FLOAT, acc_shift, 1'b1};
            msgd_pkg::PK_U8,
            msgd_pkg::PK_U16,
            msgd_pkg::PK_U32:   fin_res = '{msgd_pkg::K_UINT, acc_shift, 1'b1};
            msgd_pkg::PK_I8:
                fin_res = '{msgd_pkg::K_INT, {{24{acc_shift[7]}}, acc_shift[7:0]}, 1'b1};
            msgd_pkg::PK_I16:
                fin_res = '{msgd_pkg::K_INT, {{16{acc_shift[15]}}, acc_shift[15:0]}, 1'b1};
            msgd_pkg::PK_I32:   fin_res = '{msgd_pkg::K_INT, acc_shift, 1'b1};
            msgd_pkg::PK_RAW16,
            msgd_pkg::PK_RAW32:
            begin
                fin_raw = 1'b1;
                fin_res = '{msgd_pkg::K_RAWHDR, acc_shift, (acc_shift == 32'd0)};
            end
            default:            fin_res = '{msgd_pkg::K_UNSUP, 32'd0, 1'b1};
        endcase
    end

    // Outputs of the step.
    always_comb
    begin
        if (in_oper)
        begin
            has_result = accept && op_done;
            result     = fin_res;
        end
        else if (in_payload)
        begin
            has_result = accept;
            result     = '{msgd_pkg::K_RAWBYTE, {24'd0, byte_in}, (payload_reg == 32'd1)};
        end
        else
        begin
            has_result = accept && hdr_emit;
            result     = hdr_res;
        end
    end

    // Next state of the step.
    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        left_next    = left_reg;
        acc_next     = acc_reg;
        payload_next = payload_reg;
        if (accept)
        begin
            if (in_oper)
            begin
                acc_next  = acc_shift;
                left_next = (left_reg != 3'd0) ? left_reg - 3'd1 : 3'd0;
                if (op_done)
                begin
                    phase_next = msgd_pkg::PH_IDLE;
                    if (fin_raw)
                    begin
                        payload_next = acc_shift;
                        if (acc_shift != 32'd0)
                        begin
                            phase_next = msgd_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            else if (in_payload)
            begin
                payload_next = payload_reg - 32'd1;
                if (payload_reg == 32'd1)
                begin
                    phase_next = msgd_pkg::PH_IDLE;
                end
            end
            else
            begin
                phase_next = msgd_pkg::PH_IDLE;
                if (hdr_start)
                begin
                    phase_next   = msgd_pkg::PH_OPER;
                    pending_next = hdr_pk;
                    left_next    = hdr_nbytes;
                    acc_next     = 32'd0;
                end
                else if (hdr_raw)
                begin
                    payload_next = {27'd0, hdr_len};
                    if (hdr_len != 5'd0)
                    begin
                        phase_next = msgd_pkg::PH_PAYLOAD;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= msgd_pkg::PH_IDLE;
            pending_reg <= msgd_pkg::PK_FLOAT;
            left_reg    <= 3'd0;
            acc_reg     <= 32'd0;
            payload_reg <= 32'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            left_reg    <= left_next;
            acc_reg     <= acc_next;
            payload_reg <= payload_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/msgd_out_buf.sv
// Result register with a skid entry so the input side keeps flowing under a short stall.
`timescale 1ns / 1ps
`default_nettype none

module msgd_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire msgd_pkg::result_t push_data,
    output logic                   can_accept,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output msgd_pkg::result_t      out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    msgd_pkg::result_t out_data_reg, out_data_next;
    msgd_pkg::result_t skid_data_reg, skid_data_next;
    logic              pop;

    assign pop        = out_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // No new request is taken while the skid entry is full.
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (pop || !out_valid_reg)
        begin
            out_valid_next = push;
            out_data_next  = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/msgpack_stream_decoder_unit.sv
// Top level of the MessagePack stream decoder (legacy raw format).
//
// The block takes an encoded MessagePack stream on the bytes channel, one
// byte per request, and gives decoded results on the results channel.
// Headers that complete at once (nil, bool, fixnums, fixraw) give a result
// for the header byte itself. Typed headers collect 1, 2 or 4 big-endian
// operand bytes, and the result appears for the byte that completes them.
// A raw item gives a header result with its length, then one raw byte
// result per payload byte; the final result of every item has last set.
// The result of an accepted byte is registered in the result register, or in
// the skid entry when the receiver stalls. Throughput is one byte per cycle
// while bytes is ready; the decode step between the state registers and the
// result register is combinational. When the receiver stalls, one further result is
// held in a skid entry, and bytes is held not ready until it drains.
// Bytes that cause no result (operand bytes) are taken whenever ready.
// Reset clears the decode state to idle awaiting a header and empties
// the result register and the skid entry.
`timescale 1ns / 1ps
`default_nettype none

module msgpack_stream_decoder_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    msgd_byte_if.sink   bytes,
    msgd_result_if.source results
);

    logic              accept;
    logic              can_accept;
    logic              has_result;
    msgd_pkg::result_t step_result;
    msgd_pkg::result_t out_data;
    logic              out_valid;

    assign bytes.ready = can_accept;
    assign accept      = bytes.valid && can_accept;

    // Decode state and the per-byte step.
    msgd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .byte_in    (bytes.byte_in),
        .result     (step_result),
        .has_result (has_result)
    );

    // Result register and skid entry toward the receiver.
    msgd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (has_result),
        .push_data  (step_result),
        .can_accept (can_accept),
        .out_valid  (out_valid),
        .out_ready  (results.ready),
        .out_data   (out_data)
    );

    assign results.valid      = out_valid;
    assign results.kind       = out_data.kind;
    assign results.value_bits = out_data.value_bits;
    assign results.last       = out_data.last;

endmodule

`default_nettype wire
